### design/k_subset_enumerator_defines.svh
// Assertion macros for the k-subset enumerator.
`ifndef K_SUBSET_ENUMERATOR_DEFINES_SVH
`define K_SUBSET_ENUMERATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KSE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kse assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kse assertion failed");
`else
`define KSE_ASSERT_IMPL(label, ante, cons)
`define KSE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/kse_pkg.sv
// Package: types and constants of the k-subset enumerator.
package kse_pkg;

	localparam int MAX_OPTIONS = 16;
	localparam int IDX_W       = 4;
	localparam int SIZE_W      = 5;
	localparam int MASK_W      = 16;
	// Stored index values run past the option range once the count shrinks
	localparam int ENTRY_W     = 8;

	// Action codes of an input item
	localparam logic [1:0] ACT_ADVANCE = 2'd0;
	localparam logic [1:0] ACT_QUERY   = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_DONE
	} kse_state_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [IDX_W-1:0] query_index;
	} in_item_t;

	typedef struct packed {
		logic              combo_valid;
		logic              more_sizes;
		logic              is_member;
		logic [SIZE_W-1:0] subset_size;
		logic [MASK_W-1:0] member_mask;
	} out_item_t;

	// Sequencer to index store: one write port, one read port
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [IDX_W-1:0]   raddr;
	} store_ctl_t;

endpackage

### design/kse_index_store.sv
// Index store: sorted index list, one read port, mask and membership decode.
module kse_index_store (
	input  logic                            clk,
	input  kse_pkg::store_ctl_t             ctl,
	input  logic [kse_pkg::SIZE_W-1:0]      held,
	input  logic [kse_pkg::IDX_W-1:0]       query,
	output logic [kse_pkg::ENTRY_W-1:0]     rd_data,
	output logic [kse_pkg::MASK_W-1:0]      mask,
	output logic                            member
);
	import kse_pkg::*;

	logic [ENTRY_W-1:0] entry_q [MAX_OPTIONS];

	// Write one entry per cycle while ctl.we is set
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			entry_q[ctl.waddr] <= ctl.wdata;
		end
	end

	// Read the entry the sequencer points at
	assign rd_data = entry_q[ctl.raddr];

	// Decode the held entries into a mask and a membership hit
	always_comb begin
		mask   = '0;
		member = 1'b0;
		for (int i = 0; i < MAX_OPTIONS; i++) begin
			if (SIZE_W'(i) < held) begin
				// an index past the mask range sets no bit
				if (entry_q[i] < ENTRY_W'(MASK_W)) begin
					mask[entry_q[i][IDX_W-1:0]] = 1'b1;
				end
				if (entry_q[i] == ENTRY_W'(query)) begin
					member = 1'b1;
				end
			end
		end
	end

endmodule

### design/kse_seq.sv
// Sequencer: subset size, backward scan and tail refill over the index store.
module kse_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [1:0]                      action,
	input  logic [kse_pkg::SIZE_W-1:0]      n_eff,
	input  logic [kse_pkg::ENTRY_W-1:0]     rd_data,
	input  logic                            take,
	output logic                            idle,
	output logic                            done,
	output logic [kse_pkg::SIZE_W-1:0]      size,
	output logic                            usable,
	output kse_pkg::store_ctl_t             ctl
);
	import kse_pkg::*;

	kse_state_t         state_q, state_d;
	logic [SIZE_W-1:0]  size_q;
	logic               usable_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [ENTRY_W-1:0] run_q;
	logic [SIZE_W-1:0]  end_q;

	logic [SIZE_W-1:0] target;
	logic              mismatch;
	logic              scan_last;
	logic              fill_last;
	logic [SIZE_W-1:0] grow_size;
	logic [SIZE_W-1:0] grow_end;
	logic              grow_usable;
	logic              adv_go;

	// Shared compare unit: entry against its top value n-k+j
	assign target    = n_eff - size_q + {1'b0, ptr_q};
	assign mismatch  = rd_data != ENTRY_W'(target);
	assign scan_last = ({1'b0, ptr_q} + SIZE_W'(1)) == size_q;
	assign fill_last = ({1'b0, ptr_q} + SIZE_W'(1)) == end_q;

	// Start of the next size: indices 0..min(k+1,n)-1
	assign grow_size   = size_q + SIZE_W'(1);
	assign grow_end    = (grow_size <= n_eff) ? grow_size : n_eff;
	assign grow_usable = size_q < n_eff;

	assign adv_go = (action == ACT_ADVANCE) && (n_eff != '0) && (size_q <= n_eff);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (adv_go) begin
						state_d = (size_q != '0) ? ST_SCAN : ST_FILL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (mismatch) begin
					state_d = scan_last ? ST_DONE : ST_FILL;
				end else if (ptr_q == '0) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (fill_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: store port and status
	always_comb begin
		idle      = state_q == ST_IDLE;
		done      = state_q == ST_DONE;
		ctl.we    = ((state_q == ST_SCAN) && mismatch) || (state_q == ST_FILL);
		ctl.waddr = ptr_q;
		ctl.raddr = ptr_q;
		ctl.wdata = (state_q == ST_SCAN) ? rd_data + ENTRY_W'(1) : run_q;
	end

	assign size   = size_q;
	assign usable = usable_q;

	// Advance size, pointer and running value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			size_q   <= '0;
			usable_q <= 1'b1;
			ptr_q    <= '0;
			run_q    <= '0;
			end_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start && (action == ACT_ADVANCE)) begin
						if (n_eff == '0) begin
							usable_q <= 1'b0;
						end else if ((size_q != '0) && (size_q <= n_eff)) begin
							ptr_q <= IDX_W'(size_q - SIZE_W'(1));
						end else if (size_q <= n_eff) begin
							size_q   <= grow_size;
							end_q    <= grow_end;
							ptr_q    <= '0;
							run_q    <= '0;
							usable_q <= grow_usable;
						end else begin
							size_q   <= n_eff + SIZE_W'(1);
							usable_q <= 1'b0;
						end
					end else if (start && (action == ACT_RESTART)) begin
						size_q   <= '0;
						usable_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (mismatch) begin
						usable_q <= 1'b1;
						ptr_q    <= ptr_q + IDX_W'(1);
						run_q    <= rd_data + ENTRY_W'(2);
						end_q    <= size_q;
					end else if (ptr_q == '0) begin
						size_q   <= grow_size;
						end_q    <= grow_end;
						run_q    <= '0;
						usable_q <= grow_usable;
					end else begin
						ptr_q <= ptr_q - IDX_W'(1);
					end
				end
				ST_FILL: begin
					ptr_q <= ptr_q + IDX_W'(1);
					run_q <= run_q + ENTRY_W'(1);
				end
				default: ;
			endcase
		end
	end

endmodule

### design/k_subset_enumerator.sv
// Top level: k-subset enumerator with config register and output register.
//
//   channel   direction   handshake          payload
//   in        to block    in_valid/in_stall  in_item   (action, query_index)
//   out       from block  out_valid/out_stall out_item (flags, size, mask)
//   cfg       to block    cfg_we             cfg_wdata (option_count)
//
// Query, restart and unused codes go from idle straight to done and load their result.
// An advance runs s backward-scan steps (at most k) and then f refilled entries
// (at most MAX_OPTIONS); the single read port of the index store and the one
// compare unit make these steps serial. in_stall is high from transfer until the
// result loads. A new item is taken while the previous result waits under out_stall.
// Reset clears size to zero and marks the start usable; the index list is not cleared.
`include "k_subset_enumerator_defines.svh"

module k_subset_enumerator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [kse_pkg::SIZE_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  kse_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output kse_pkg::out_item_t                out_item
);
	import kse_pkg::*;

	logic [SIZE_W-1:0] option_count_q;
	logic [SIZE_W-1:0] n_eff;
	logic [1:0]        action_q;
	logic [IDX_W-1:0]  query_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic               in_xfer;
	logic               load;
	logic               seq_idle;
	logic               seq_done;
	logic [SIZE_W-1:0]  size;
	logic               usable;
	logic [SIZE_W-1:0]  held;
	logic [ENTRY_W-1:0] rd_data;
	logic [MASK_W-1:0]  mask;
	logic               member;
	logic               combo_valid;
	store_ctl_t         ctl;

	// Option count register, clipped to the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_count_q <= '0;
		end else if (cfg_we) begin
			option_count_q <= cfg_wdata;
		end
	end

	assign n_eff = (option_count_q > SIZE_W'(MAX_OPTIONS)) ? SIZE_W'(MAX_OPTIONS)
		: option_count_q;

	// Input transfer while the sequencer is idle
	assign in_stall = !seq_idle;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_q <= in_item.action;
			query_q  <= in_item.query_index;
		end
	end

	kse_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_xfer),
		.action  (in_item.action),
		.n_eff   (n_eff),
		.rd_data (rd_data),
		.take    (load),
		.idle    (seq_idle),
		.done    (seq_done),
		.size    (size),
		.usable  (usable),
		.ctl     (ctl)
	);

	assign held = (size < n_eff) ? size : n_eff;

	kse_index_store u_store (
		.clk     (clk),
		.ctl     (ctl),
		.held    (held),
		.query   (query_q),
		.rd_data (rd_data),
		.mask    (mask),
		.member  (member)
	);

	// Load the result once the output register is free
	assign load        = seq_done && (!out_valid_q || !out_stall);
	assign combo_valid = usable && (n_eff != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.combo_valid <= combo_valid;
			out_q.more_sizes  <= combo_valid && (size < n_eff);
			out_q.is_member   <= (action_q == ACT_QUERY) && member;
			out_q.subset_size <= size;
			out_q.member_mask <= mask;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Checks
	`KSE_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall)
	`KSE_ASSERT_IMPL(a_no_overwrite, load, !out_valid_q || !out_stall)
	`KSE_ASSERT_IMPL(a_more_needs_valid, out_valid_q && out_q.more_sizes, out_q.combo_valid)
	`KSE_ASSERT_IMPL(a_size_bound, 1'b1, size <= SIZE_W'(MAX_OPTIONS + 1))

endmodule
